// ----- rtl/upn_pkg.sv -----
`default_nettype none

package upn_pkg;

	localparam int MAX_URL     = 256;
	localparam int SLASH_DEPTH = 64;

	localparam int LEN_W  = $clog2(MAX_URL + 1);
	localparam int POS_W  = $clog2(MAX_URL);
	localparam int CNT_W  = $clog2(SLASH_DEPTH + 1);
	localparam int SIDX_W = $clog2(SLASH_DEPTH);

	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_QUERY  = 8'h3f;
	localparam logic [7:0] CASE_BIT  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [3:0] HEX_ALPHA = 4'd10;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_TRUNC  = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_BAD_HEX  = 2'd1;
	localparam logic [1:0] STS_TOO_LONG = 2'd2;
	localparam logic [1:0] STS_STACK    = 2'd3;

	typedef enum logic [6:0] {
		ST_USUAL = 7'b0000001,
		ST_QUERY = 7'b0000010,
		ST_SLASH = 7'b0000100,
		ST_DOT   = 7'b0001000,
		ST_DDOT  = 7'b0010000,
		ST_PCT1  = 7'b0100000,
		ST_PCT2  = 7'b1000000
	} parse_state_t;

	typedef struct packed {
		logic [7:0] url_byte;
		logic       last_byte;
		logic       split_query;
	} item_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] out_byte;
		logic [8:0] new_length;
		logic       done_res;
		logic [1:0] status;
		logic       has_query;
		logic [7:0] query_start;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stk_ctl_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t       h;
		logic [7:0] lc;
		lc    = c | CASE_BIT;
		h.ok  = 1'b0;
		h.nib = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			h.ok  = 1'b1;
			h.nib = c[3:0];
		end else if (lc >= CH_LOW_A && lc <= CH_LOW_F) begin
			h.ok  = 1'b1;
			h.nib = 4'(lc[3:0] - CH_LOW_A[3:0] + HEX_ALPHA);
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/upn_slash_stack.sv -----
`default_nettype none

module upn_slash_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  upn_pkg::stk_ctl_t              ctl,
	input  logic [upn_pkg::POS_W-1:0]      push_pos,
	output logic [upn_pkg::CNT_W-1:0]      count,
	output logic [upn_pkg::POS_W-1:0]      top,
	output logic [upn_pkg::POS_W-1:0]      second
);
	import upn_pkg::*;

	// top two entries live in flops, deeper ones in the memory
	logic [POS_W-1:0]  slash_mem_q [SLASH_DEPTH];
	logic [POS_W-1:0]  top_q;
	logic [POS_W-1:0]  nxt_q;
	logic [POS_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [CNT_W-1:0]  wsum;
	logic [CNT_W-1:0]  rsum;
	logic [SIDX_W-1:0] waddr;
	logic [SIDX_W-1:0] raddr;

	always_comb begin
		cnt_d = cnt_q;
		if (ctl.clear) begin
			cnt_d = '0;
		end else if (ctl.push) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (ctl.pop) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	assign wsum  = cnt_q - CNT_W'(2);
	assign rsum  = cnt_d - CNT_W'(3);
	assign waddr = wsum[SIDX_W-1:0];
	assign raddr = rsum[SIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// prefetch of the entry below second, bypassed on push
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slash_mem_q[waddr] <= nxt_q;
			rd_q               <= nxt_q;
		end else begin
			rd_q <= slash_mem_q[raddr];
		end
		if (ctl.push) begin
			top_q <= push_pos;
			nxt_q <= top_q;
		end else if (ctl.pop) begin
			top_q <= nxt_q;
			nxt_q <= rd_q;
		end
	end

	assign count  = cnt_q;
	assign top    = top_q;
	assign second = nxt_q;

endmodule

`default_nettype wire

// ----- rtl/url_path_normalizer_top.sv -----
// input transfer to result passes the input register and the result register
// throughput: one byte per cycle while result_stall is low; the parse step is
// combinational, top two slash positions in flops and the next prefetched from memory
// reset: arst_n clears parse state, length, counts and valids at once; the slash
// memory is not cleared and needs no clearing pass
`default_nettype none

module url_path_normalizer_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  upn_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output upn_pkg::result_t result
);
	import upn_pkg::*;

	item_t        item_s1;
	logic         valid_s1;
	logic         adv;
	result_t      res_q;
	logic         res_valid_q;

	parse_state_t st_q, st_d;
	parse_state_t ret_q, ret_d;
	logic [3:0]       hn_q, hn_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             qv_q, qv_d;
	logic [POS_W-1:0] qpos_q, qpos_d;
	logic [1:0]       err_q, err_d;

	stk_ctl_t         stk_ctl;
	logic [CNT_W-1:0] stk_cnt;
	logic [POS_W-1:0] stk_top;
	logic [POS_W-1:0] stk_second;

	logic [7:0]       c;
	logic [7:0]       ab;
	logic             app_req;
	logic             trunc_req;
	logic [1:0]       act;
	logic [LEN_W-1:0] target;
	hex_t             hx;
	result_t          res_d;
	logic             hq;

	assign adv        = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	assign c  = item_s1.url_byte;
	assign hx = hex_value(c);

	always_comb begin
		st_d      = st_q;
		ret_d     = ret_q;
		hn_d      = hn_q;
		len_d     = len_q;
		qv_d      = qv_q;
		qpos_d    = qpos_q;
		err_d     = err_q;
		ab        = c;
		app_req   = 1'b0;
		trunc_req = 1'b0;
		act       = ACT_NONE;
		target    = '0;
		stk_ctl   = '0;

		if (err_q == STS_OK) begin
			unique case (st_q)
				ST_SLASH: begin
					if (c == CH_SLASH) begin
						st_d = ST_SLASH;
					end else if (c == CH_DOT) begin
						st_d = ST_DOT;
					end else if (c == CH_PCT) begin
						ret_d = st_q;
						st_d  = ST_PCT1;
					end else begin
						app_req = 1'b1;
						st_d    = ST_USUAL;
					end
				end
				ST_DOT: begin
					if (c == CH_SLASH) begin
						st_d = ST_SLASH;
					end else if (c == CH_DOT) begin
						st_d = ST_DDOT;
					end else if (c == CH_PCT) begin
						ret_d = st_q;
						st_d  = ST_PCT1;
					end else begin
						app_req = 1'b1;
						st_d    = ST_USUAL;
					end
				end
				ST_DDOT: begin
					if (c == CH_SLASH) begin
						trunc_req = 1'b1;
						st_d      = ST_SLASH;
					end else if (c == CH_PCT) begin
						ret_d = st_q;
						st_d  = ST_PCT1;
					end else begin
						app_req = 1'b1;
						st_d    = ST_USUAL;
					end
				end
				ST_PCT1: begin
					if (!hx.ok) begin
						err_d = STS_BAD_HEX;
					end else begin
						hn_d = hx.nib;
						st_d = ST_PCT2;
					end
				end
				ST_PCT2: begin
					if (!hx.ok) begin
						err_d = STS_BAD_HEX;
					end else begin
						ab      = {hn_q, hx.nib};
						st_d    = ret_q;
						app_req = 1'b1;
					end
				end
				default: begin
					if (c == CH_PCT) begin
						ret_d = ST_USUAL;
						st_d  = ST_PCT1;
					end else begin
						app_req = 1'b1;
					end
				end
			endcase
		end

		if (app_req) begin
			if (len_q == LEN_W'(MAX_URL)) begin
				err_d = STS_TOO_LONG;
			end else if (ab == CH_SLASH && stk_cnt == CNT_W'(SLASH_DEPTH)) begin
				err_d = STS_STACK;
			end else begin
				act          = ACT_APPEND;
				stk_ctl.push = (ab == CH_SLASH);
				if (ab == CH_QUERY && !qv_q) begin
					qv_d   = 1'b1;
					qpos_d = len_q[POS_W-1:0];
				end
				len_d = len_q + LEN_W'(1);
				// a raw slash in the usual state opens a slash run
				if (ab == CH_SLASH && st_q != ST_PCT2 && st_d == st_q) begin
					st_d = ST_SLASH;
				end
			end
		end

		if (trunc_req) begin
			act = ACT_TRUNC;
			if (stk_cnt == '0) begin
				target = '0;
			end else if (LEN_W'(stk_top) + LEN_W'(1) == len_q && len_q >= LEN_W'(2)) begin
				stk_ctl.pop = 1'b1;
				if (stk_cnt > CNT_W'(1)) begin
					target = LEN_W'(stk_second) + LEN_W'(1);
				end else begin
					target = '0;
				end
			end else begin
				target = LEN_W'(stk_top) + LEN_W'(1);
			end
			if (qv_q && LEN_W'(qpos_q) >= target) begin
				qv_d = 1'b0;
			end
			len_d = target;
		end

		hq                = item_s1.last_byte && item_s1.split_query && qv_d;
		res_d.action      = act;
		res_d.out_byte    = (act == ACT_APPEND) ? ab : 8'd0;
		res_d.new_length  = len_d;
		res_d.done_res    = item_s1.last_byte;
		res_d.status      = item_s1.last_byte ? err_d : STS_OK;
		res_d.has_query   = hq;
		res_d.query_start = hq ? qpos_d : 8'd0;

		if (item_s1.last_byte) begin
			st_d          = ST_USUAL;
			ret_d         = ST_USUAL;
			hn_d          = '0;
			len_d         = '0;
			qv_d          = 1'b0;
			err_d         = STS_OK;
			stk_ctl.clear = 1'b1;
		end

		if (!adv) begin
			stk_ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_USUAL;
			ret_q <= ST_USUAL;
			hn_q  <= '0;
			len_q <= '0;
			qv_q  <= 1'b0;
			err_q <= STS_OK;
		end else if (adv) begin
			st_q  <= st_d;
			ret_q <= ret_d;
			hn_q  <= hn_d;
			len_q <= len_d;
			qv_q  <= qv_d;
			err_q <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qpos_q <= qpos_d;
		end
	end

	upn_slash_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (stk_ctl),
		.push_pos (len_q[POS_W-1:0]),
		.count    (stk_cnt),
		.top      (stk_top),
		.second   (stk_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt <= CNT_W'(SLASH_DEPTH))
		else $error("slash stack count beyond depth");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_URL))
		else $error("output length beyond limit");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last_byte |=> len_q == '0 && stk_cnt == '0 && err_q == STS_OK)
		else $error("state not cleared after last byte");

	a_append_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.action == ACT_APPEND |-> res_q.new_length != '0)
		else $error("append with zero length");

endmodule

`default_nettype wire

// ----- tb/url_path_normalizer_top_test.sv -----
`timescale 1ns / 1ps

module url_path_normalizer_top_test;
	import upn_pkg::*;

	typedef logic [7:0] bytes_t[$];

	localparam int HOLD_CYCLES  = 200;
	localparam int RANDOM_ITEMS = 800;
	localparam int STEADY_ITEMS = 300;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	logic idle_on = 1'b1;
	logic holding = 1'b0;
	event hold_go;

	result_t edits_due[$];
	int n_errors   = 0;
	int n_checked  = 0;
	int n_bytes    = 0;
	int n_urls     = 0;
	int n_appends  = 0;
	int n_truncs   = 0;
	int n_err_ends = 0;

	// normalizer state
	parse_state_t pst;
	parse_state_t ret_st;
	logic [3:0]   hi_nib;
	int unsigned  olen;
	int unsigned  scount;
	int unsigned  qpos;
	logic [7:0]   spos[SLASH_DEPTH];
	logic         qvalid;
	logic [1:0]   err;

	url_path_normalizer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_state();
		pst    = ST_USUAL;
		ret_st = ST_USUAL;
		hi_nib = '0;
		olen   = 0;
		scount = 0;
		qvalid = 1'b0;
		qpos   = 0;
		err    = STS_OK;
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		logic [7:0] lc;
		lc = c | CASE_BIT;
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (lc >= CH_LOW_A && lc <= CH_LOW_F) return int'(lc - CH_LOW_A) + 10;
		return -1;
	endfunction

	function automatic logic [1:0] put_byte(logic [7:0] b);
		if (olen >= MAX_URL) begin
			err = STS_TOO_LONG;
			return ACT_NONE;
		end
		if (b == CH_SLASH) begin
			if (scount >= SLASH_DEPTH) begin
				err = STS_STACK;
				return ACT_NONE;
			end
			spos[6'(scount)] = olen[7:0];
			scount++;
		end
		if (b == CH_QUERY && !qvalid) begin
			qvalid = 1'b1;
			qpos   = olen;
		end
		olen++;
		return ACT_APPEND;
	endfunction

	function automatic logic [1:0] cut_to_parent();
		int unsigned tgt;
		int unsigned top;
		tgt = 0;
		if (scount != 0) begin
			top = 32'(spos[6'(scount - 1)]);
			if (top + 1 == olen && olen >= 2) begin
				scount--;
				if (scount != 0) tgt = 32'(spos[6'(scount - 1)]) + 1;
			end else begin
				tgt = top + 1;
			end
		end
		if (qvalid && qpos >= tgt) qvalid = 1'b0;
		olen = tgt;
		return ACT_TRUNC;
	endfunction

	function automatic void start_escape();
		ret_st = pst;
		pst    = ST_PCT1;
	endfunction

	function automatic result_t normalize_byte(item_t it);
		result_t    r;
		logic [7:0] c;
		logic [1:0] act;
		int         h;
		c   = it.url_byte;
		act = ACT_NONE;
		if (err == STS_OK) begin
			case (pst)
				ST_SLASH: begin
					if (c == CH_DOT) begin
						pst = ST_DOT;
					end else if (c == CH_PCT) begin
						start_escape();
					end else if (c != CH_SLASH) begin
						act = put_byte(c);
						pst = ST_USUAL;
					end
				end
				ST_DOT: begin
					if (c == CH_SLASH) begin
						pst = ST_SLASH;
					end else if (c == CH_DOT) begin
						pst = ST_DDOT;
					end else if (c == CH_PCT) begin
						start_escape();
					end else begin
						act = put_byte(c);
						pst = ST_USUAL;
					end
				end
				ST_DDOT: begin
					if (c == CH_SLASH) begin
						act = cut_to_parent();
						pst = ST_SLASH;
					end else if (c == CH_PCT) begin
						start_escape();
					end else begin
						act = put_byte(c);
						pst = ST_USUAL;
					end
				end
				ST_PCT1, ST_PCT2: begin
					h = hex_digit(c);
					if (h < 0) begin
						err = STS_BAD_HEX;
					end else if (pst == ST_PCT1) begin
						hi_nib = 4'(h);
						pst    = ST_PCT2;
					end else begin
						c   = {hi_nib, 4'(h)};
						pst = ret_st;
						act = put_byte(c);
					end
				end
				default: begin
					if (c == CH_SLASH) begin
						act = put_byte(c);
						if (act == ACT_APPEND) pst = ST_SLASH;
					end else if (c == CH_PCT) begin
						pst = ST_USUAL;
						start_escape();
					end else begin
						act = put_byte(c);
					end
				end
			endcase
		end
		if (act == ACT_APPEND) n_appends++;
		if (act == ACT_TRUNC) n_truncs++;
		r            = '0;
		r.action     = act;
		r.out_byte   = (act == ACT_APPEND) ? c : 8'd0;
		r.new_length = olen[8:0];
		r.done_res   = it.last_byte;
		if (it.last_byte) begin
			r.status      = err;
			r.has_query   = it.split_query && qvalid;
			r.query_start = r.has_query ? qpos[7:0] : 8'd0;
			if (err != STS_OK) n_err_ends++;
			clear_state();
		end
		return r;
	endfunction

	function automatic void report(string what, result_t want, result_t got);
		n_errors++;
		if (n_errors <= 10) begin
			$display("mismatch (%s) at %0t", what, $realtime);
			$display("  exp act=%0d byte=%h len=%0d done=%0b sts=%0d q=%0b qpos=%0d",
				want.action, want.out_byte, want.new_length, want.done_res,
				want.status, want.has_query, want.query_start);
			$display("  got act=%0d byte=%h len=%0d done=%0b sts=%0d q=%0b qpos=%0d",
				got.action, got.out_byte, got.new_length, got.done_res,
				got.status, got.has_query, got.query_start);
		end
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		string   bad;
		if (edits_due.size() == 0) begin
			report("no transfer pending", '0, got);
			return;
		end
		want = edits_due.pop_front();
		n_checked++;
		bad = "";
		if (got.action !== want.action) bad = {bad, " action"};
		if (got.out_byte !== want.out_byte) bad = {bad, " out_byte"};
		if (got.new_length !== want.new_length) bad = {bad, " new_length"};
		if (got.done_res !== want.done_res) bad = {bad, " done_res"};
		if (got.status !== want.status) bad = {bad, " status"};
		if (got.has_query !== want.has_query) bad = {bad, " has_query"};
		if (got.query_start !== want.query_start) bad = {bad, " query_start"};
		if (bad != "") report(bad, want, got);
	endfunction

	// receive side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (result_valid && !result_stall) check_result(result);
		result_stall <= holding || (idle_on && $urandom_range(99) < 24);
	end

	// long receiver hold-off, counted here
	initial forever begin
		@(hold_go);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	function automatic bytes_t text(string s);
		bytes_t u;
		for (int i = 0; i < s.len(); i++) u.push_back(s[i]);
		return u;
	endfunction

	function automatic logic [7:0] hex_char();
		logic [3:0] v;
		v = 4'($urandom_range(15));
		if (v < 4'd10) return CH_ZERO + {4'd0, v};
		return ($urandom_range(1) ? CH_LOW_A : (CH_LOW_A & ~CASE_BIT)) + {4'd0, v - 4'd10};
	endfunction

	function automatic bytes_t make_url(int unsigned max_tokens);
		bytes_t      u;
		int unsigned k;
		string       enc[4] = '{"%2F", "%2f", "%2e", "%3F"};
		repeat ($urandom_range(max_tokens, 1)) begin
			k = $urandom_range(99);
			if (k < 24) begin
				u.push_back(CH_SLASH);
			end else if (k < 32) begin
				u.push_back(CH_DOT);
			end else if (k < 40) begin
				u.push_back(CH_DOT);
				u.push_back(CH_DOT);
			end else if (k < 50) begin
				u.push_back(CH_PCT);
				u.push_back(hex_char());
				u.push_back(hex_char());
			end else if (k < 54) begin
				u = {u, text(enc[$urandom_range(3)])};
			end else if (k < 57) begin
				// broken or cut-off escape
				u.push_back(CH_PCT);
				if ($urandom_range(1)) u.push_back(8'($urandom_range(255)));
			end else if (k < 63) begin
				u.push_back(CH_QUERY);
			end else if (k < 69) begin
				u.push_back(8'($urandom_range(255)));
			end else begin
				u.push_back(8'($urandom_range(8'h7a, 8'h61)));
			end
		end
		return u;
	endfunction

	task automatic send_byte(logic [7:0] b, logic lst, logic spl);
		item_t it;
		it.url_byte    = b;
		it.last_byte   = lst;
		it.split_query = spl;
		if (idle_on && $urandom_range(99) < 20) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		edits_due.push_back(normalize_byte(it));
		n_bytes++;
	endtask

	task automatic send_url(bytes_t u, logic spl);
		int n;
		n = u.size();
		for (int i = 0; i < n; i++)
			send_byte(u[i], i == n - 1, (i == n - 1) ? spl : 1'($urandom_range(1)));
		n_urls++;
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		while (edits_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_paths();
		send_url(text("//a?/./b"), 1'b1);
		send_url(text("a/../"), 1'b1);
		send_url(text("/.x"), 1'($urandom_range(1)));
	endtask

	task automatic test_directed_escapes();
		send_url(text("/.%41"), 1'b1);
		send_url(text("%2F?%g"), 1'b1);
		send_url('{8'hff, 8'h00, CH_PCT, 8'h34}, 1'b0);
	endtask

	task automatic test_length_limit();
		bytes_t u;
		repeat (MAX_URL - 1) u.push_back(8'h62);
		u.push_back(CH_QUERY);
		send_url(u, 1'b1);
		u = {};
		repeat (MAX_URL + 2) u.push_back(8'h63);
		send_url(u, 1'b1);
	endtask

	task automatic test_slash_stack();
		bytes_t u;
		repeat (SLASH_DEPTH) begin
			u.push_back(CH_SLASH);
			u.push_back(8'h78);
		end
		u.push_back(CH_SLASH);
		u.push_back(8'h79);
		send_url(u, 1'b0);
	endtask

	task automatic test_random(int n, logic idle);
		int start;
		idle_on <= idle;
		start = n_bytes;
		while (n_bytes - start < n)
			send_url(make_url(($urandom_range(19) == 0) ? 120 : 16), 1'($urandom_range(1)));
	endtask

	task automatic test_backpressure();
		-> hold_go;
		repeat (10) send_url(make_url(12), 1'($urandom_range(1)));
	endtask

	task automatic test_drain_pause();
		wait_drain();
		repeat (4) send_url(make_url(10), 1'($urandom_range(1)));
	endtask

	initial begin
		clear_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_paths();
		test_directed_escapes();
		test_length_limit();
		test_slash_stack();
		test_random(STEADY_ITEMS, 1'b0);
		test_backpressure();
		test_drain_pause();
		test_random(RANDOM_ITEMS - STEADY_ITEMS, 1'b1);
		wait_drain();
		repeat (10) @(posedge clk);
		$display("checked %0d results over %0d urls (%0d bytes)", n_checked, n_urls, n_bytes);
		$display("saw %0d appends, %0d parent truncations, %0d urls ending in error",
			n_appends, n_truncs, n_err_ends);
		if (n_errors == 0 && edits_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule
